// ===== src/vlt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the voxel line traversal block.
// Used by every module of the block; depends on nothing.
package vlt_pkg;

	localparam int XY_W      = 9;   // input x/y coordinate width
	localparam int Z_W       = 6;   // input z coordinate width
	localparam int PXY_W     = 10;  // signed walk position x/y
	localparam int PZ_W      = 7;   // signed walk position z
	localparam int COST_W    = 20;  // per-axis initial cost
	localparam int ACC_W     = 22;  // accumulated cost
	localparam int CNT_W     = 6;   // voxel count within one line
	localparam int DIV_W     = 18;  // dividend / quotient width (dominant * 512)
	localparam int DIV_CNT_W = 5;

	localparam int MAX_STEPS = 50;
	localparam int WORLD_XY  = 512;
	localparam int WORLD_Z   = 64;

	localparam logic [COST_W-1:0] UNIT_COST     = COST_W'(512);
	localparam logic [COST_W-1:0] ZERO_LEN_COST = COST_W'(32'h3FFF_FFFF / 1024);

	// one classified line, handed from front to back
	typedef struct packed {
		logic [XY_W-1:0]   start_x;
		logic [XY_W-1:0]   start_y;
		logic [Z_W-1:0]    start_z;
		logic [XY_W-1:0]   end_x;
		logic [XY_W-1:0]   end_y;
		logic [Z_W-1:0]    end_z;
		logic              neg_x;
		logic              neg_y;
		logic              neg_z;
		logic [COST_W-1:0] cost_x;
		logic [COST_W-1:0] cost_y;
		logic [COST_W-1:0] cost_z;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} front_state_t;

endpackage

// ===== src/vlt_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the axis step costs.
// Depends on vlt_pkg.
module vlt_div import vlt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_W-1:0]   dividend,
	input  logic [XY_W-1:0]    divisor,
	output logic [DIV_W-1:0]   quotient,
	output logic               done
);

	logic [XY_W-1:0]      rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [XY_W-1:0]      dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [XY_W:0]        trial;
	logic                 fit;
	logic [XY_W:0]        diff;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fit   = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operands are latched at start; the ports may move on afterwards
	// remainder stays below the divisor, so it fits the divisor width
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? diff[XY_W-1:0] : trial[XY_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fit};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== src/vlt_front.sv =====
`timescale 1ns / 1ps
// Front end: takes a line item, finds the dominant axis and signs, and runs the
// two cost divisions before handing a job to the queue. Depends on vlt_pkg, vlt_div.
module vlt_front import vlt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [XY_W-1:0] start_x,
	input  logic [XY_W-1:0] start_y,
	input  logic [Z_W-1:0]  start_z,
	input  logic [XY_W-1:0] end_x,
	input  logic [XY_W-1:0] end_y,
	input  logic [Z_W-1:0]  end_z,
	input  q_status_t       q_st,
	output logic            push,
	output job_t            job
);

	front_state_t state_q, state_d;
	logic         div_start;
	logic         done0, done1;
	logic [DIV_W-1:0] quo0, quo1;

	logic [XY_W:0] dx, dy;
	logic [Z_W:0]  dz;
	logic [XY_W-1:0] ax, ay, az;
	logic xdom, ydom, zdom;
	logic [XY_W-1:0] dom, len0, len1;

	logic [XY_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [Z_W-1:0]  sz_q, ez_q;
	logic            nx_q, ny_q, nz_q;
	logic [XY_W-1:0] ax_q, ay_q, az_q;
	logic            xdom_q, ydom_q;
	logic [COST_W-1:0] q0c, q1c;

	// classification straight from the ports at accept
	assign dx   = {1'b0, end_x} - {1'b0, start_x};
	assign dy   = {1'b0, end_y} - {1'b0, start_y};
	assign dz   = {1'b0, end_z} - {1'b0, start_z};
	assign ax   = dx[XY_W] ? XY_W'(-dx) : dx[XY_W-1:0];
	assign ay   = dy[XY_W] ? XY_W'(-dy) : dy[XY_W-1:0];
	assign az   = XY_W'(dz[Z_W] ? Z_W'(-dz) : dz[Z_W-1:0]);
	assign xdom = (ax >= ay) && (ax >= az);
	assign ydom = !xdom && (ay >= az);
	assign zdom = !xdom && !ydom;
	assign dom  = xdom ? ax : (ydom ? ay : az);
	assign len0 = xdom ? ay : ax;
	assign len1 = zdom ? ay : az;

	vlt_div u_div0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({dom, XY_W'(0)}),
		.divisor  (len0),
		.quotient (quo0),
		.done     (done0)
	);

	vlt_div u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({dom, XY_W'(0)}),
		.divisor  (len1),
		.quotient (quo1),
		.done     (done1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					div_start = 1'b1;
					state_d   = FR_DIV;
				end
			end
			FR_DIV: begin
				if (done0 && done1) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				if (!q_st.full) begin
					push    = 1'b1;
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sx_q   <= start_x;
			sy_q   <= start_y;
			sz_q   <= start_z;
			ex_q   <= end_x;
			ey_q   <= end_y;
			ez_q   <= end_z;
			nx_q   <= dx[XY_W];
			ny_q   <= dy[XY_W];
			nz_q   <= dz[Z_W];
			ax_q   <= ax;
			ay_q   <= ay;
			az_q   <= az;
			xdom_q <= xdom;
			ydom_q <= ydom;
		end
	end

	assign q0c = COST_W'(quo0);
	assign q1c = COST_W'(quo1);

	always_comb begin
		job.start_x = sx_q;
		job.start_y = sy_q;
		job.start_z = sz_q;
		job.end_x   = ex_q;
		job.end_y   = ey_q;
		job.end_z   = ez_q;
		job.neg_x   = nx_q;
		job.neg_y   = ny_q;
		job.neg_z   = nz_q;
		// divider 0 serves the first non-dominant axis, divider 1 the second
		job.cost_x  = xdom_q ? UNIT_COST : ((ax_q == '0) ? ZERO_LEN_COST : q0c);
		job.cost_y  = ydom_q ? UNIT_COST :
			((ay_q == '0) ? ZERO_LEN_COST : (xdom_q ? q0c : q1c));
		job.cost_z  = (!xdom_q && !ydom_q) ? UNIT_COST :
			((az_q == '0) ? ZERO_LEN_COST : q1c);
	end

endmodule

// ===== src/vlt_queue.sv =====
`timescale 1ns / 1ps
// Two-entry job queue between front and back.
// Depends on vlt_pkg.
module vlt_queue import vlt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      wr_job,
	input  logic      pop,
	output job_t      rd_job,
	output q_status_t q_st
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	assign rd_job     = mem_q[rd_ptr_q];
	assign q_st.full  = cnt_q == 2'd2;
	assign q_st.empty = cnt_q == 2'd0;

endmodule

// ===== src/vlt_back.sv =====
`timescale 1ns / 1ps
// Back end: walks one job voxel by voxel, smallest accumulated cost first,
// and drives the output register. Depends on vlt_pkg.
module vlt_back import vlt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  job_t                    job,
	input  q_status_t               q_st,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [PXY_W-1:0] voxel_x,
	output logic signed [PXY_W-1:0] voxel_y,
	output logic signed [PZ_W-1:0]  voxel_z,
	output logic                    last
);

	localparam logic [PXY_W:0] XY_LIM = (PXY_W + 1)'(WORLD_XY);
	localparam logic [PZ_W:0]  Z_LIM  = (PZ_W + 1)'(WORLD_Z);

	job_t             job_q;
	logic             act_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PXY_W-1:0] px_q, py_q;
	logic [PZ_W-1:0]  pz_q;
	logic [ACC_W-1:0] tx_q, ty_q, tz_q;
	logic             out_valid_q;
	logic [PXY_W-1:0] vx_q, vy_q;
	logic [PZ_W-1:0]  vz_q;
	logic             last_q;

	logic             advance;
	logic             at_end, cap, zsel, xsel, hit, fin;
	logic [PXY_W:0]   nx, ny;
	logic [PZ_W:0]    nz;

	assign pop     = !act_q && !q_st.empty;
	assign advance = act_q && (!out_valid_q || out_ready);

	assign at_end = (px_q == {1'b0, job_q.end_x}) && (py_q == {1'b0, job_q.end_y})
		&& (pz_q == {1'b0, job_q.end_z});
	assign cap    = cnt_q == CNT_W'(MAX_STEPS - 1);

	// z wins ties against both, x needs to be strictly below y
	assign zsel = (tz_q <= tx_q) && (tz_q <= ty_q);
	assign xsel = !zsel && (tx_q < ty_q);

	assign nx = {px_q[PXY_W-1], px_q} + (job_q.neg_x ? '1 : (PXY_W + 1)'(1));
	assign ny = {py_q[PXY_W-1], py_q} + (job_q.neg_y ? '1 : (PXY_W + 1)'(1));
	assign nz = {pz_q[PZ_W-1], pz_q} + (job_q.neg_z ? '1 : (PZ_W + 1)'(1));

	always_comb begin
		if (zsel) begin
			hit = $signed(nz) >= $signed(Z_LIM);
		end else if (xsel) begin
			hit = $signed(nx) >= $signed(XY_LIM);
		end else begin
			hit = $signed(ny) >= $signed(XY_LIM);
		end
	end

	assign fin = cap || at_end || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (pop) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (advance) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (fin) begin
					act_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
			px_q  <= PXY_W'(job.start_x);
			py_q  <= PXY_W'(job.start_y);
			pz_q  <= PZ_W'(job.start_z);
			tx_q  <= ACC_W'(job.cost_x);
			ty_q  <= ACC_W'(job.cost_y);
			tz_q  <= ACC_W'(job.cost_z);
		end else if (advance && !fin) begin
			if (zsel) begin
				pz_q <= nz[PZ_W-1:0];
				tz_q <= tz_q + {1'b0, job_q.cost_z, 1'b0};
			end else if (xsel) begin
				px_q <= nx[PXY_W-1:0];
				tx_q <= tx_q + {1'b0, job_q.cost_x, 1'b0};
			end else begin
				py_q <= ny[PXY_W-1:0];
				ty_q <= ty_q + {1'b0, job_q.cost_y, 1'b0};
			end
		end
		if (advance) begin
			vx_q   <= px_q;
			vy_q   <= py_q;
			vz_q   <= pz_q;
			last_q <= fin;
		end
	end

	assign out_valid = out_valid_q;
	assign voxel_x   = vx_q;
	assign voxel_y   = vy_q;
	assign voxel_z   = vz_q;
	assign last      = last_q;

endmodule

// ===== src/voxel_line_traversal.sv =====
`timescale 1ns / 1ps
// Voxel line traversal: integer 3D DDA walk from a start voxel toward an end voxel.
// Top level; depends on vlt_pkg, vlt_front, vlt_queue, vlt_back.
//
// Usage:
// - Input channel (in_valid/in_ready) takes one line item: start and end voxel.
// - Output channel (out_valid/out_ready) returns the voxels of that line in walk
//   order, starting with the start voxel; last is set on the final one. A line
//   gives 1 to 50 voxels.
// - The front runs its two bit-serial cost dividers, then hands the job to a
//   two-entry queue; the back walks one voxel per cycle while out_ready is
//   high. The front takes no new item until its job is in the queue, and its
//   dividers run while the back walks the previous line.
// - The output is a register: voxels keep coming while out_ready is high. When
//   out_ready is low, the voxel holds and the walk pauses; the queue fills and
//   then in_ready drops.
// - Reset (arst_n low) drops any line in flight and empties the queue; the
//   block is ready to accept an item as soon as reset is released.
module voxel_line_traversal import vlt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [XY_W-1:0]         start_x,
	input  logic [XY_W-1:0]         start_y,
	input  logic [Z_W-1:0]          start_z,
	input  logic [XY_W-1:0]         end_x,
	input  logic [XY_W-1:0]         end_y,
	input  logic [Z_W-1:0]          end_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [PXY_W-1:0] voxel_x,
	output logic signed [PXY_W-1:0] voxel_y,
	output logic signed [PZ_W-1:0]  voxel_z,
	output logic                    last
);

	q_status_t q_st;
	logic      push;
	logic      pop;
	job_t      wr_job;
	job_t      rd_job;

	vlt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.start_x  (start_x),
		.start_y  (start_y),
		.start_z  (start_z),
		.end_x    (end_x),
		.end_y    (end_y),
		.end_z    (end_z),
		.q_st     (q_st),
		.push     (push),
		.job      (wr_job)
	);

	vlt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.q_st   (q_st)
	);

	vlt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rd_job),
		.q_st      (q_st),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.voxel_x   (voxel_x),
		.voxel_y   (voxel_y),
		.voxel_z   (voxel_z),
		.last      (last)
	);

endmodule

// ===== src/vlt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the voxel output stream, bound to the top level.
// Depends on vlt_pkg and voxel_line_traversal.
module vlt_checker import vlt_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [PXY_W-1:0] voxel_x,
	input logic signed [PXY_W-1:0] voxel_y,
	input logic signed [PZ_W-1:0]  voxel_z,
	input logic                    last
);

	logic             out_acc;
	logic             mid_q;
	logic [CNT_W-1:0] len_q;
	logic [PXY_W-1:0] prev_x_q, prev_y_q;
	logic [PZ_W-1:0]  prev_z_q;
	logic [PXY_W-1:0] dx, dy;
	logic [PZ_W-1:0]  dz;
	logic             mx, my, mz;
	logic             ux, uy, uz;

	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
			len_q <= '0;
		end else if (out_acc) begin
			mid_q <= !last;
			len_q <= last ? '0 : len_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_x_q <= voxel_x;
			prev_y_q <= voxel_y;
			prev_z_q <= voxel_z;
		end
	end

	assign dx = voxel_x - prev_x_q;
	assign dy = voxel_y - prev_y_q;
	assign dz = voxel_z - prev_z_q;
	assign mx = dx != '0;
	assign my = dy != '0;
	assign mz = dz != '0;
	assign ux = (dx == PXY_W'(1)) || (dx == '1);
	assign uy = (dy == PXY_W'(1)) || (dy == '1);
	assign uz = (dz == PZ_W'(1)) || (dz == '1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(voxel_x) && $stable(voxel_y)
			&& $stable(voxel_z) && $stable(last))
		else $error("voxel changed while stalled");

	// consecutive voxels of one line are one step apart along exactly one axis
	a_unit_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && mid_q |-> $onehot({mx, my, mz}) && (!mx || ux) && (!my || uy)
			&& (!mz || uz))
		else $error("voxel is not a single step from the previous one");

	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (len_q == CNT_W'(MAX_STEPS - 1)) |-> last)
		else $error("line longer than the voxel limit");

endmodule

bind voxel_line_traversal vlt_checker u_vlt_checker (.*);
